@@ design/lpr_pkg.sv @@
// Shared types and constants of the length-prefixed record ring.
package lpr_pkg;

   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned LANES     = 8;
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned LEN_BITS  = 9;
   // Span values at or above this cap behave alike against a nine-bit length.
   localparam int unsigned SPAN_CAP  = 512;

   typedef enum logic [2:0] {
      OP_ENQ_BEGIN  = 3'd0,
      OP_ENQ_BYTE   = 3'd1,
      OP_DEQ_START  = 3'd2,
      OP_DEQ_FINISH = 3'd3,
      OP_READ_BYTE  = 3'd4
   } lpr_op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_ORDER   = 2'd3
   } lpr_status_type;

   typedef enum logic [1:0] {
      KIND_PLAIN  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_FETCH  = 2'd2
   } lpr_kind_type;

   typedef struct packed {
      lpr_status_type status;
      lpr_kind_type   kind;
      logic [2:0]     lane;
      logic [9:0]     first_offset;
      logic [9:0]     limit;
      logic [9:0]     room;
   } lpr_issue_type;

endpackage

@@ design/lpr_mem.sv @@
// Word-organised ring store with byte-lane write enables and a registered read.
module lpr_mem #(
   parameter int unsigned WORDS = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [lpr_pkg::LANES-1:0]           wr_mask,
   input  logic [$clog2(WORDS)-1:0]            wr_addr,
   input  logic [lpr_pkg::WORD_BITS-1:0]       wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(WORDS)-1:0]            rd_addr,
   output logic [lpr_pkg::WORD_BITS-1:0]       rd_data
);

   logic [lpr_pkg::WORD_BITS-1:0] mem_ff [WORDS];
   logic [lpr_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < lpr_pkg::LANES; i++) begin
         if (wr_en && wr_mask[i]) begin
            mem_ff[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lpr_ctrl.sv @@
// Pointer state, space checks and store access for each accepted transfer.
module lpr_ctrl #(
   parameter int unsigned RING_BYTES = 512
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  logic [2:0]                                 operation,
   input  logic [8:0]                                 record_bytes,
   input  logic [7:0]                                 data_byte,
   input  logic [8:0]                                 byte_offset,
   output lpr_pkg::lpr_issue_type                     issue,
   output logic                                       wr_en,
   output logic [lpr_pkg::LANES-1:0]                  wr_mask,
   output logic [$clog2(RING_BYTES)-4:0]              wr_addr,
   output logic [lpr_pkg::WORD_BITS-1:0]              wr_data,
   output logic                                       rd_en,
   output logic [$clog2(RING_BYTES)-4:0]              rd_addr
);

   localparam int unsigned PW = $clog2(RING_BYTES);
   localparam int unsigned CW = (PW + 1 > 10) ? PW + 1 : 10;
   localparam int unsigned SW = ((PW > 10) ? PW : 10) + 1;
   localparam int unsigned RW = PW + 4;
   localparam logic [PW:0] RING_P  = (PW+1)'(RING_BYTES);
   localparam logic [PW:0] HDR_P   = (PW+1)'(lpr_pkg::HDR_BYTES);
   localparam logic [PW:0] ALIGN_P = (PW+1)'(lpr_pkg::HDR_BYTES - 1);

   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] fc_ff, fc_in;
   logic [8:0]    left_ff, left_in;
   logic          open_ff, open_in;

   logic [PW:0]   gap, free_b, used_b;
   logic [CW-1:0] need;
   logic [PW:0]   hdr_end;
   logic [PW-1:0] wp_hdr;
   logic [PW:0]   fc_sum;
   logic [PW-1:0] fc_step;
   logic [PW:0]   fc_al;
   logic [PW-1:0] commit_pos;
   logic [9:0]    step;
   logic [SW-1:0] rp_sum;
   logic [PW-1:0] rp_adv;
   logic [PW:0]   start, room_full, limit_full;
   logic [RW-1:0] off_red;
   logic [PW-1:0] off_mod;

   // Occupancy of the ring; both pointers always sit on header boundaries.
   always_comb begin
      if (rp_ff == wp_ff) begin
         gap = RING_P;
      end else if (rp_ff > wp_ff) begin
         gap = {1'b0, rp_ff} - {1'b0, wp_ff};
      end else begin
         gap = RING_P - ({1'b0, wp_ff} - {1'b0, rp_ff});
      end
      free_b = gap - HDR_P;
      used_b = (rp_ff == wp_ff) ? '0 : RING_P - gap;
      need   = CW'(record_bytes) + CW'(lpr_pkg::HDR_BYTES);
   end

   // Pointer arithmetic with wrap at the ring end.
   always_comb begin
      hdr_end    = {1'b0, wp_ff} + HDR_P;
      wp_hdr     = (hdr_end >= RING_P) ? PW'(hdr_end - RING_P) : hdr_end[PW-1:0];
      fc_sum     = {1'b0, fc_ff} + (PW+1)'(1);
      fc_step    = (fc_sum >= RING_P) ? '0 : fc_sum[PW-1:0];
      fc_al      = ({1'b0, fc_step} + ALIGN_P) & ~ALIGN_P;
      commit_pos = (fc_al >= RING_P) ? '0 : fc_al[PW-1:0];
      step       = (10'(record_bytes) + 10'(2 * lpr_pkg::HDR_BYTES - 1))
                   & ~10'(lpr_pkg::HDR_BYTES - 1);
      rp_sum     = SW'(rp_ff) + SW'(step);
      rp_adv     = (rp_sum >= SW'(RING_BYTES)) ? PW'(rp_sum - SW'(RING_BYTES))
                                               : PW'(rp_sum);
      start      = {1'b0, rp_ff} + HDR_P;
      room_full  = RING_P - start;
      limit_full = used_b - HDR_P;
   end

   // Fetch offset reduced modulo the ring size by a short restoring chain.
   always_comb begin
      logic [RW-1:0] v;
      v = RW'(byte_offset);
      for (int k = 3; k >= 0; k--) begin
         if (v >= (RW'(RING_BYTES) << k)) begin
            v = v - (RW'(RING_BYTES) << k);
         end
      end
      off_red = v;
      off_mod = PW'(off_red);
   end

   always_comb begin
      rp_in   = rp_ff;
      wp_in   = wp_ff;
      fc_in   = fc_ff;
      left_in = left_ff;
      open_in = open_ff;
      issue.status       = lpr_pkg::ST_OK;
      issue.kind         = lpr_pkg::KIND_PLAIN;
      issue.lane         = off_mod[2:0];
      issue.first_offset = 10'(start);
      issue.limit        = (CW'(limit_full) > CW'(lpr_pkg::SPAN_CAP))
                           ? 10'(lpr_pkg::SPAN_CAP) : 10'(limit_full);
      issue.room         = (CW'(room_full) > CW'(lpr_pkg::SPAN_CAP))
                           ? 10'(lpr_pkg::SPAN_CAP) : 10'(room_full);
      wr_en   = 1'b0;
      wr_mask = '1;
      wr_addr = wp_ff[PW-1:3];
      wr_data = lpr_pkg::WORD_BITS'(record_bytes);
      rd_en   = 1'b0;
      rd_addr = rp_ff[PW-1:3];
      case (operation)
         lpr_pkg::OP_ENQ_BEGIN: begin
            if (open_ff) begin
               issue.status = lpr_pkg::ST_ORDER;
            end else if (CW'(free_b) < need) begin
               issue.status = lpr_pkg::ST_NO_ROOM;
            end else begin
               wr_en = accept;
               fc_in = wp_hdr;
               if (record_bytes == '0) begin
                  wp_in = wp_hdr;
               end else begin
                  left_in = record_bytes;
                  open_in = 1'b1;
               end
            end
         end
         lpr_pkg::OP_ENQ_BYTE: begin
            if (!open_ff) begin
               issue.status = lpr_pkg::ST_ORDER;
            end else begin
               wr_en   = accept;
               wr_mask = lpr_pkg::LANES'(1) << fc_ff[2:0];
               wr_addr = fc_ff[PW-1:3];
               wr_data = {lpr_pkg::LANES{data_byte}};
               fc_in   = fc_step;
               left_in = left_ff - 9'd1;
               if (left_ff == 9'd1) begin
                  open_in = 1'b0;
                  wp_in   = commit_pos;
               end
            end
         end
         lpr_pkg::OP_DEQ_START: begin
            if (used_b == '0) begin
               issue.status = lpr_pkg::ST_EMPTY;
            end else begin
               issue.kind = lpr_pkg::KIND_HEADER;
               rd_en      = accept;
            end
         end
         lpr_pkg::OP_DEQ_FINISH: begin
            if (used_b == '0) begin
               issue.status = lpr_pkg::ST_EMPTY;
            end else if (CW'(step) > CW'(used_b)) begin
               issue.status = lpr_pkg::ST_ORDER;
            end else begin
               rp_in = rp_adv;
            end
         end
         lpr_pkg::OP_READ_BYTE: begin
            issue.kind = lpr_pkg::KIND_FETCH;
            rd_en      = accept;
            rd_addr    = off_mod[PW-1:3];
         end
         default: begin
            issue.status = lpr_pkg::ST_ORDER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= '0;
         wp_ff   <= '0;
         fc_ff   <= '0;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else if (accept) begin
         rp_ff   <= rp_in;
         wp_ff   <= wp_in;
         fc_ff   <= fc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

`ifndef SYNTH
   a_ptr_aligned: assert property (@(posedge clock) disable iff (reset)
      rp_ff[2:0] == 3'd0 && wp_ff[2:0] == 3'd0)
      else $error("ring pointer off a header boundary");

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> left_ff != 9'd0)
      else $error("open record with no bytes outstanding");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, rp_ff} < RING_P && {1'b0, wp_ff} < RING_P && {1'b0, fc_ff} < RING_P)
      else $error("ring pointer beyond the ring end");
`endif

endmodule

@@ design/lpr_resp.sv @@
// Issue stage and result register: finishes header checks and byte selection.
module lpr_resp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  lpr_pkg::lpr_issue_type            issue,
   input  logic [lpr_pkg::WORD_BITS-1:0]     rd_data,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [8:0]                        rsp_entry_length,
   output logic [9:0]                        rsp_first_offset,
   output logic [8:0]                        rsp_first_length,
   output logic [8:0]                        rsp_second_length,
   output logic [7:0]                        rsp_fetched_byte
);

   logic                   s1_valid_ff, s1_valid_in;
   lpr_pkg::lpr_issue_type s1_issue_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [8:0]             elen_ff, elen_in;
   logic [9:0]             foff_ff, foff_in;
   logic [8:0]             flen_ff, flen_in;
   logic [8:0]             slen_ff, slen_in;
   logic [7:0]             fetch_ff, fetch_in;
   logic                   advance;
   logic [8:0]             hdr_len;
   logic                   hdr_bad;

   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign busy    = s1_valid_ff && !advance;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      hdr_len   = rd_data[lpr_pkg::LEN_BITS-1:0];
      hdr_bad   = (|rd_data[lpr_pkg::WORD_BITS-1:lpr_pkg::LEN_BITS])
                  || ({1'b0, hdr_len} > s1_issue_ff.limit);
      status_in = s1_issue_ff.status;
      elen_in   = '0;
      foff_in   = '0;
      flen_in   = '0;
      slen_in   = '0;
      fetch_in  = '0;
      case (s1_issue_ff.kind)
         lpr_pkg::KIND_HEADER: begin
            if (hdr_bad) begin
               status_in = lpr_pkg::ST_ORDER;
            end else begin
               elen_in = hdr_len;
               foff_in = s1_issue_ff.first_offset;
               if ({1'b0, hdr_len} > s1_issue_ff.room) begin
                  flen_in = s1_issue_ff.room[8:0];
                  slen_in = hdr_len - s1_issue_ff.room[8:0];
               end else begin
                  flen_in = hdr_len;
               end
            end
         end
         lpr_pkg::KIND_FETCH: begin
            fetch_in = rd_data[8*s1_issue_ff.lane +: 8];
         end
         default: begin
            status_in = s1_issue_ff.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_issue_ff <= issue;
      end
      if (advance) begin
         status_ff <= status_in;
         elen_ff   <= elen_in;
         foff_ff   <= foff_in;
         flen_ff   <= flen_in;
         slen_ff   <= slen_in;
         fetch_ff  <= fetch_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_length  = elen_ff;
   assign rsp_first_offset  = foff_ff;
   assign rsp_first_length  = flen_ff;
   assign rsp_second_length = slen_ff;
   assign rsp_fetched_byte  = fetch_ff;

`ifndef SYNTH
   a_accept_fills_issue: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer missing from the issue stage");

   a_busy_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_valid_ff && rsp_stall)
      else $error("issue stage held without a stalled result");
`endif

endmodule

@@ design/length_prefixed_record_ring_unit.sv @@
// Top level of the length-prefixed record ring unit.
//
// A byte ring of RING_BYTES bytes (a multiple of 8) holding records, each an
// 8-byte little-endian length header followed by its data bytes. Commands
// arrive on the req_ channel and each accepted transfer yields exactly one
// result transfer on the rsp_ channel, in order. A transfer takes place on a
// rising edge where valid is high and stall is low.
// Throughput is one command per cycle while the receiver does not stall. An
// accepted command is held in the issue stage, together with the registered
// read of the word-wide ring store, and its result then passes into the
// result register, its data checked and trimmed on the way.
// When the receiver stalls, a finished result waits in the result register
// and one further command is still taken into the issue stage; only then is
// req_stall raised, and it falls as soon as the result register drains.
// Reset clears the read, write and fill pointers and closes any open record,
// so the ring is empty; store contents are left undefined until written.
module length_prefixed_record_ring_unit #(
   parameter int unsigned RING_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [8:0] req_record_bytes,
   input  logic [7:0] req_data_byte,
   input  logic [8:0] req_byte_offset,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [8:0] rsp_entry_length,
   output logic [9:0] rsp_first_offset,
   output logic [8:0] rsp_first_length,
   output logic [8:0] rsp_second_length,
   output logic [7:0] rsp_fetched_byte
);

   localparam int unsigned WORDS = RING_BYTES / lpr_pkg::HDR_BYTES;
   localparam int unsigned AW    = $clog2(WORDS);

   logic                              accept;
   logic                              busy;
   lpr_pkg::lpr_issue_type            issue;
   logic                              wr_en;
   logic [lpr_pkg::LANES-1:0]         wr_mask;
   logic [AW-1:0]                     wr_addr;
   logic [lpr_pkg::WORD_BITS-1:0]     wr_data;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   logic [lpr_pkg::WORD_BITS-1:0]     rd_data;

   // A command is taken whenever the issue stage is free or about to drain.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // Pointer state and the single store access a command may need: a whole
   // header word written or read, or one byte lane written or read.
   lpr_ctrl #(
      .RING_BYTES (RING_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .record_bytes (req_record_bytes),
      .data_byte    (req_data_byte),
      .byte_offset  (req_byte_offset),
      .issue        (issue),
      .wr_en        (wr_en),
      .wr_mask      (wr_mask),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr)
   );

   // Ring store, one 64-bit word per header slot with byte enables.
   lpr_mem #(
      .WORDS (WORDS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_mask (wr_mask),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Header validation, wrap split and byte selection into the result register.
   lpr_resp u_resp (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .issue             (issue),
      .rd_data           (rd_data),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_entry_length  (rsp_entry_length),
      .rsp_first_offset  (rsp_first_offset),
      .rsp_first_length  (rsp_first_length),
      .rsp_second_length (rsp_second_length),
      .rsp_fetched_byte  (rsp_fetched_byte)
   );

endmodule

@@ dv/length_prefixed_record_ring_unit_test.sv @@
// Self-checking testbench for the length-prefixed record ring unit.
module length_prefixed_record_ring_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The ring size must match the instance below; records are aligned to
   // header-sized slots and one slot always stays free.
   localparam int unsigned RING     = 512;
   localparam int unsigned LEN_MAX  = (1 << lpr_pkg::LEN_BITS) - 1;
   localparam int unsigned OP_CODES = 8;
   localparam int unsigned HDR      = lpr_pkg::HDR_BYTES;

   // One command as it travels on the request channel.
   typedef struct {
      logic [2:0] operation;
      logic [8:0] record_bytes;
      logic [7:0] data_byte;
      logic [8:0] byte_offset;
   } ring_command_type;

   // One result as it is expected on the response channel. Fields that an
   // operation does not produce are zero.
   typedef struct {
      logic [1:0] status;
      logic [8:0] entry_length;
      logic [9:0] first_offset;
      logic [8:0] first_length;
      logic [8:0] second_length;
      logic [7:0] fetched_byte;
   } ring_outcome_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_operation = '0;
   logic [8:0] req_record_bytes = '0;
   logic [7:0] req_data_byte = '0;
   logic [8:0] req_byte_offset = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [8:0] rsp_entry_length;
   logic [9:0] rsp_first_offset;
   logic [8:0] rsp_first_length;
   logic [8:0] rsp_second_length;
   logic [7:0] rsp_fetched_byte;

   // Commands waiting to be driven, and the results they are owed, in order.
   // Each command yields exactly one result, so the two are filled together
   // when the command is generated.
   ring_command_type command_q[$];
   ring_outcome_type outcome_q[$];

   // Shadow copy of the ring. shadow_written marks bytes that have been stored
   // at least once, so that the stimulus never reads an undefined byte.
   logic [7:0]  shadow_ring[RING];
   bit          shadow_written[RING];
   int unsigned shadow_rd;
   int unsigned shadow_wr;
   int unsigned shadow_fill;
   int unsigned shadow_left;
   bit          shadow_open;

   int unsigned commands_posted = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned errors = 0;
   logic        req_fired = 1'b0;

   length_prefixed_record_ring_unit #(
      .RING_BYTES(RING)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_record_bytes(req_record_bytes),
      .req_data_byte(req_data_byte),
      .req_byte_offset(req_byte_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_length(rsp_entry_length),
      .rsp_first_offset(rsp_first_offset),
      .rsp_first_length(rsp_first_length),
      .rsp_second_length(rsp_second_length),
      .rsp_fetched_byte(rsp_fetched_byte)
   );

   // 12 ns period, first rising edge at 6 ns.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow ring arithmetic.
   // ---------------------------------------------------------------------

   // Space left for a new record, with the reserved slot taken off.
   function automatic int unsigned shadow_free();
      int unsigned gap;
      if (shadow_rd == shadow_wr) gap = RING;
      else if (shadow_rd > shadow_wr) gap = shadow_rd - shadow_wr;
      else gap = RING - (shadow_wr - shadow_rd);
      return (gap >= HDR) ? gap - HDR : 0;
   endfunction

   // Bytes of committed records between the read and write pointers.
   function automatic int unsigned shadow_used();
      if (shadow_rd == shadow_wr) return 0;
      if (shadow_rd > shadow_wr) return RING - (shadow_rd - shadow_wr);
      return shadow_wr - shadow_rd;
   endfunction

   function automatic int unsigned pad_to_slot(int unsigned bytes);
      return (bytes + HDR - 1) / HDR * HDR;
   endfunction

   // Publishes the write pointer at the slot boundary after the last byte.
   function automatic void shadow_publish(int unsigned pos);
      int unsigned slot;
      slot = pad_to_slot(pos);
      shadow_wr = (slot >= RING) ? 0 : slot;
   endfunction

   // Applies one command to the shadow ring and returns the result it owes.
   function automatic ring_outcome_type ring_step_outcome(ring_command_type c);
      ring_outcome_type o;
      int unsigned      avail;
      int unsigned      step;
      int unsigned      base;
      int unsigned      room;
      logic [63:0]      hdr_word;
      o = '{default: '0};
      o.status = lpr_pkg::ST_OK;
      case (c.operation)
         lpr_pkg::OP_ENQ_BEGIN: begin
            if (shadow_open) begin
               o.status = lpr_pkg::ST_ORDER;
            end else if (shadow_free() < c.record_bytes + HDR) begin
               o.status = lpr_pkg::ST_NO_ROOM;
            end else begin
               // Little-endian header: the length in the low bytes, zeros above.
               hdr_word = 64'(c.record_bytes);
               for (int k = 0; k < HDR; k++) begin
                  shadow_ring[(shadow_wr + k) % RING] = hdr_word[8*k +: 8];
                  shadow_written[(shadow_wr + k) % RING] = 1'b1;
               end
               shadow_fill = (shadow_wr + HDR) % RING;
               if (c.record_bytes == 0) begin
                  shadow_publish(shadow_fill);
               end else begin
                  shadow_left = c.record_bytes;
                  shadow_open = 1'b1;
               end
            end
         end
         lpr_pkg::OP_ENQ_BYTE: begin
            if (!shadow_open) begin
               o.status = lpr_pkg::ST_ORDER;
            end else begin
               shadow_ring[shadow_fill] = c.data_byte;
               shadow_written[shadow_fill] = 1'b1;
               shadow_fill = (shadow_fill + 1) % RING;
               shadow_left--;
               if (shadow_left == 0) begin
                  shadow_open = 1'b0;
                  shadow_publish(shadow_fill);
               end
            end
         end
         lpr_pkg::OP_DEQ_START: begin
            avail = shadow_used();
            if (avail == 0) begin
               o.status = lpr_pkg::ST_EMPTY;
            end else begin
               hdr_word = '0;
               for (int k = 0; k < HDR; k++)
                  hdr_word |= 64'(shadow_ring[(shadow_rd + k) % RING]) << (8 * k);
               if (hdr_word > LEN_MAX || hdr_word > avail - HDR) begin
                  o.status = lpr_pkg::ST_ORDER;
               end else begin
                  // The data start is not wrapped, so it may equal the ring size.
                  base = shadow_rd + HDR;
                  room = RING - base;
                  o.entry_length = hdr_word[8:0];
                  o.first_offset = 10'(base);
                  if (hdr_word > room) begin
                     o.first_length  = 9'(room);
                     o.second_length = 9'(hdr_word - room);
                  end else begin
                     o.first_length = hdr_word[8:0];
                  end
               end
            end
         end
         lpr_pkg::OP_DEQ_FINISH: begin
            avail = shadow_used();
            step = pad_to_slot(c.record_bytes + HDR);
            if (avail == 0) o.status = lpr_pkg::ST_EMPTY;
            else if (step > avail) o.status = lpr_pkg::ST_ORDER;
            else shadow_rd = (shadow_rd + step) % RING;
         end
         lpr_pkg::OP_READ_BYTE: begin
            o.fetched_byte = shadow_ring[c.byte_offset % RING];
         end
         default: begin
            o.status = lpr_pkg::ST_ORDER;
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation.
   // ---------------------------------------------------------------------

   // Queues one command together with the result it is owed.
   function automatic ring_outcome_type post_command(logic [2:0] op, int unsigned rec,
                                                     int unsigned dbyte, int unsigned offs);
      ring_command_type c;
      ring_outcome_type o;
      c.operation    = op;
      c.record_bytes = 9'(rec);
      c.data_byte    = 8'(dbyte);
      c.byte_offset  = 9'(offs);
      o = ring_step_outcome(c);
      command_q.push_back(c);
      outcome_q.push_back(o);
      commands_posted++;
      return o;
   endfunction

   // A dequeue start reads the header slot at the read pointer, so it is
   // only issued once every byte of that slot has been written.
   function automatic bit header_readable();
      if (shadow_used() == 0) return 1'b1;
      for (int k = 0; k < HDR; k++)
         if (!shadow_written[(shadow_rd + k) % RING]) return 1'b0;
      return 1'b1;
   endfunction

   // Chooses a ring position that has been written, leaning on the two ends.
   // Returns -1 while nothing has been written.
   function automatic int pick_written_offset();
      int unsigned roll;
      int unsigned origin;
      roll = $urandom_range(0, 7);
      origin = (roll == 0) ? 0 : (roll == 1) ? RING - 1 : $urandom_range(0, RING - 1);
      for (int k = 0; k < RING; k++)
         if (shadow_written[(origin + k) % RING]) return (origin + k) % RING;
      return -1;
   endfunction

   function automatic int unsigned data_value();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      return (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : $urandom_range(0, 255);
   endfunction

   // Mostly short records, some medium, a few long, and now and then the
   // longest length, which can never fit.
   function automatic int unsigned record_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 16);
      if (roll < 94) return $urandom_range(17, 64);
      if (roll < 99) return $urandom_range(65, 300);
      return LEN_MAX;
   endfunction

   // Mostly whole produce and consume sequences with random content; the rest
   // is out-of-order, unknown and mismatched commands plus buffer reads.
   task automatic random_traffic(int unsigned count);
      int unsigned      goal;
      int unsigned      roll;
      int               offs;
      ring_outcome_type head;
      goal = commands_posted + count;
      while (commands_posted < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 48) begin
            // A fresh record, or the rest of one left open by a stray begin.
            if (!shadow_open)
               void'(post_command(lpr_pkg::OP_ENQ_BEGIN, record_length(), $urandom,
                                  $urandom));
            while (shadow_open)
               void'(post_command(lpr_pkg::OP_ENQ_BYTE, $urandom, data_value(), $urandom));
         end else if (roll < 85) begin
            // Normally consume what the start reported; sometimes skip by a wrong
            // length, which can leave the read pointer on data instead of a header.
            if (header_readable()) begin
               head = post_command(lpr_pkg::OP_DEQ_START, $urandom, $urandom, $urandom);
               if (head.status == lpr_pkg::ST_OK && $urandom_range(0, 9) != 0)
                  void'(post_command(lpr_pkg::OP_DEQ_FINISH, head.entry_length, $urandom,
                                     $urandom));
               else
                  void'(post_command(lpr_pkg::OP_DEQ_FINISH, $urandom_range(0, 40),
                                     $urandom, $urandom));
            end else begin
               void'(post_command(lpr_pkg::OP_DEQ_FINISH, $urandom_range(0, 40), $urandom,
                                  $urandom));
            end
         end else begin
            case ($urandom_range(0, 5))
               0: void'(post_command(lpr_pkg::OP_ENQ_BEGIN, record_length(), $urandom,
                                     $urandom));
               1: void'(post_command(lpr_pkg::OP_ENQ_BYTE, $urandom, data_value(),
                                     $urandom));
               2: void'(post_command(3'($urandom_range(lpr_pkg::OP_READ_BYTE + 1,
                                                       OP_CODES - 1)),
                                     $urandom, $urandom, $urandom));
               3: void'(post_command(lpr_pkg::OP_DEQ_FINISH, $urandom_range(0, LEN_MAX),
                                     $urandom, $urandom));
               default: begin
                  offs = pick_written_offset();
                  if (offs >= 0)
                     void'(post_command(lpr_pkg::OP_READ_BYTE, $urandom, $urandom, offs));
               end
            endcase
         end
      end
   endtask

   // Holds the sender back until every owed result has been received.
   task automatic wait_drained();
      while (command_q.size() != 0 || outcome_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver. Inputs change on the falling edge. A new command is only
   // offered once the previous one has made its transfer, so a payload never
   // changes while it is stalled, and the idle choice ignores req_stall.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      ring_command_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (command_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            upcoming = command_q.pop_front();
            req_valid        <= 1'b1;
            req_operation    <= upcoming.operation;
            req_record_bytes <= upcoming.record_bytes;
            req_data_byte    <= upcoming.data_byte;
            req_byte_offset  <= upcoming.byte_offset;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Reports one differing field of a result.
   function automatic void check_field(string label, logic [9:0] want, logic [9:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response monitor. Both channels are sampled on the rising edge; a
   // request transfer is noted for the driver, and each response transfer is
   // compared with the oldest owed result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_results
      ring_outcome_type want;
      req_fired <= req_valid && !req_stall && !reset;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result expected none actual status %0d length %0d", $time,
                     rsp_status, rsp_entry_length);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("entry_length", want.entry_length, rsp_entry_length);
            check_field("first_offset", want.first_offset, rsp_first_offset);
            check_field("first_length", want.first_length, rsp_first_length);
            check_field("second_length", want.second_length, rsp_second_length);
            check_field("fetched_byte", want.fetched_byte, rsp_fetched_byte);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence: reset, a directed opening, then random traffic in four
   // idling phases with a full drain between them.
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      shadow_rd   = 0;
      shadow_wr   = 0;
      shadow_fill = 0;
      shadow_left = 0;
      shadow_open = 1'b0;
      for (int k = 0; k < RING; k++) begin
         shadow_ring[k]    = '0;
         shadow_written[k] = 1'b0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening, without idling. An empty ring refuses both halves of
      // a dequeue, and a data byte with no open record is out of order, as is
      // every unknown operation code.
      void'(post_command(lpr_pkg::OP_DEQ_START, 0, 0, 0));
      void'(post_command(lpr_pkg::OP_DEQ_FINISH, 0, 0, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BYTE, 0, 8'hFF, 0));
      for (int code = lpr_pkg::OP_READ_BYTE + 1; code < OP_CODES; code++)
         void'(post_command(3'(code), LEN_MAX, 8'hFF, LEN_MAX));
      // The largest record that could ever fit is the ring less two slots;
      // one byte more and the longest length are both refused.
      void'(post_command(lpr_pkg::OP_ENQ_BEGIN, LEN_MAX, 0, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BEGIN, RING - 2 * HDR + 1, 0, 0));
      // A zero-length record commits at once and can be dequeued straight away.
      void'(post_command(lpr_pkg::OP_ENQ_BEGIN, 0, 0, 0));
      void'(post_command(lpr_pkg::OP_READ_BYTE, 0, 0, 0));
      void'(post_command(lpr_pkg::OP_DEQ_START, 0, 0, 0));
      // Consuming more than is committed is out of order and changes nothing.
      void'(post_command(lpr_pkg::OP_DEQ_FINISH, HDR + 1, 0, 0));
      void'(post_command(lpr_pkg::OP_DEQ_FINISH, 0, 0, 0));
      // A short record, with a second begin while it is still being filled.
      void'(post_command(lpr_pkg::OP_ENQ_BEGIN, 3, 0, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BEGIN, 2, 0, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BYTE, 0, 8'h00, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BYTE, 0, 8'hFF, 0));
      void'(post_command(lpr_pkg::OP_ENQ_BYTE, 0, 8'hA5, 0));
      void'(post_command(lpr_pkg::OP_DEQ_START, 0, 0, 0));
      void'(post_command(lpr_pkg::OP_READ_BYTE, 0, 0, 2 * HDR + 1));
      void'(post_command(lpr_pkg::OP_DEQ_FINISH, 2, 0, 0));

      random_traffic(60);
      wait_drained();

      sender_idle_pct = 53;
      random_traffic(110);
      wait_drained();

      sender_idle_pct    = 0;
      receiver_stall_pct = 53;
      random_traffic(110);
      wait_drained();

      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      random_traffic(110);
      wait_drained();

      // Allow for a stray late result before judging the run.
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASS length_prefixed_record_ring_unit");
      end else begin
         $display("FAIL length_prefixed_record_ring_unit");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #3_000_000;
      $display("FAIL length_prefixed_record_ring_unit");
      $finish;
   end

endmodule

@@ files.f @@
design/lpr_pkg.sv
design/lpr_mem.sv
design/lpr_ctrl.sv
design/lpr_resp.sv
design/length_prefixed_record_ring_unit.sv
dv/length_prefixed_record_ring_unit_test.sv
